// File: hw/rtl/ecal_pkg.sv
// ----------------------------------------------------------------------------
// ecal_pkg: shared types and constants of the epoch to calendar converter
// Register codes, field widths, the flag and result structures and the two
// month tables used by the date stages.
// ----------------------------------------------------------------------------
package ecal_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 17;
	localparam int unsigned ZONE_W      = 17;

	localparam logic [CFG_INDEX_W-1:0] REG_ZONE_OFFSET = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DAYLIGHT    = 2'd1;

	localparam int unsigned SECS_PER_HOUR = 3600;

	typedef struct packed {
		logic daylight;
		logic clamped;
	} flags_t;

	typedef struct packed {
		logic [4:0]  hour_of_day;
		logic [5:0]  minute_of_hour;
		logic [5:0]  second_of_minute;
		logic [2:0]  week_day;
		logic [11:0] years_since_1900;
		logic [8:0]  day_of_year;
		logic [3:0]  month_index;
		logic [4:0]  day_of_month;
		logic        daylight_flag;
		logic        clamped;
	} cal_t;

	function automatic logic [8:0] month_start(input logic [3:0] m0);
		case (m0)
			4'd0:    month_start = 9'd0;
			4'd1:    month_start = 9'd31;
			4'd2:    month_start = 9'd59;
			4'd3:    month_start = 9'd90;
			4'd4:    month_start = 9'd120;
			4'd5:    month_start = 9'd151;
			4'd6:    month_start = 9'd181;
			4'd7:    month_start = 9'd212;
			4'd8:    month_start = 9'd243;
			4'd9:    month_start = 9'd273;
			4'd10:   month_start = 9'd304;
			4'd11:   month_start = 9'd334;
			default: month_start = 9'd0;
		endcase
	endfunction

	// Day of a March-based year on which each month starts.
	function automatic logic [8:0] march_start(input logic [3:0] mp);
		case (mp)
			4'd0:    march_start = 9'd0;
			4'd1:    march_start = 9'd31;
			4'd2:    march_start = 9'd61;
			4'd3:    march_start = 9'd92;
			4'd4:    march_start = 9'd122;
			4'd5:    march_start = 9'd153;
			4'd6:    march_start = 9'd184;
			4'd7:    march_start = 9'd214;
			4'd8:    march_start = 9'd245;
			4'd9:    march_start = 9'd275;
			4'd10:   march_start = 9'd306;
			4'd11:   march_start = 9'd337;
			default: march_start = 9'd0;
		endcase
	endfunction

endpackage

// File: hw/rtl/ecal_if.sv
// ----------------------------------------------------------------------------
// ecal_if: channel interfaces of the epoch to calendar converter
// Time stamp input, calendar result output and configuration write channel.
// ----------------------------------------------------------------------------
interface ecal_stamp_if #(parameter int unsigned EPOCH_SECONDS_BITS = 36);
	logic                          valid;
	logic                          ready;
	logic [EPOCH_SECONDS_BITS-1:0] epoch_seconds;
	modport source (output valid, output epoch_seconds, input ready);
	modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_cal_if;
	logic        valid;
	logic        ready;
	logic [4:0]  hour_of_day;
	logic [5:0]  minute_of_hour;
	logic [5:0]  second_of_minute;
	logic [2:0]  week_day;
	logic [11:0] years_since_1900;
	logic [8:0]  day_of_year;
	logic [3:0]  month_index;
	logic [4:0]  day_of_month;
	logic        daylight_flag;
	logic        clamped;
	modport source (output valid, output hour_of_day, output minute_of_hour,
		output second_of_minute, output week_day, output years_since_1900,
		output day_of_year, output month_index, output day_of_month,
		output daylight_flag, output clamped, input ready);
	modport sink (input valid, input hour_of_day, input minute_of_hour,
		input second_of_minute, input week_day, input years_since_1900,
		input day_of_year, input month_index, input day_of_month,
		input daylight_flag, input clamped, output ready);
endinterface

interface ecal_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [16:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/ecal_adjust.sv
// ----------------------------------------------------------------------------
// ecal_adjust: configuration registers and zone adjustment stage
// Holds the zone offset and daylight setting, applies them to the incoming
// time and clamps a negative result to zero.
// ----------------------------------------------------------------------------
module ecal_adjust #(
	parameter int unsigned EPOCH_SECONDS_BITS = 36
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	ecal_cfg_if.sink                      cfg,
	input  logic                          in_valid,
	input  logic [EPOCH_SECONDS_BITS-1:0] epoch_seconds,
	output logic                          valid_s1,
	output logic [EPOCH_SECONDS_BITS:0]   secs_s1,
	output ecal_pkg::flags_t              flags_s1
);
	import ecal_pkg::*;

	localparam int unsigned UW = EPOCH_SECONDS_BITS + 1;
	localparam int unsigned TW = EPOCH_SECONDS_BITS + 2;

	logic [ZONE_W-1:0] zone_q;
	logic              daylight_q;
	logic [TW-1:0]     adj;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q     <= '0;
			daylight_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ZONE_OFFSET: zone_q     <= cfg.data[ZONE_W-1:0];
				REG_DAYLIGHT:    daylight_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign adj = {2'b00, epoch_seconds}
		- {{(TW-ZONE_W){zone_q[ZONE_W-1]}}, zone_q}
		+ (daylight_q ? TW'(SECS_PER_HOUR) : TW'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			secs_s1           <= adj[TW-1] ? UW'(0) : adj[UW-1:0];
			flags_s1.daylight <= daylight_q;
			flags_s1.clamped  <= adj[TW-1];
		end
	end

endmodule

// File: hw/rtl/ecal_daydiv.sv
// ----------------------------------------------------------------------------
// ecal_daydiv: seconds to day count and second of day
// Divides by 86400 as a shift by seven and two reciprocal divisions by 675
// over the upper and lower parts, four stages deep.
// ----------------------------------------------------------------------------
module ecal_daydiv #(
	parameter int unsigned EPOCH_SECONDS_BITS = 36
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   valid_s1,
	input  logic [EPOCH_SECONDS_BITS:0]            secs_s1,
	input  ecal_pkg::flags_t                       flags_s1,
	output logic                                   valid_s5,
	output logic [((EPOCH_SECONDS_BITS-15 > 20) ?
		EPOCH_SECONDS_BITS-15 : 20):0]              z_s5,
	output logic [EPOCH_SECONDS_BITS-15:0]          dp4_s5,
	output logic [16:0]                            tod_s5,
	output ecal_pkg::flags_t                       flags_s5
);
	import ecal_pkg::*;

	localparam int unsigned UW  = EPOCH_SECONDS_BITS + 1;
	localparam int unsigned AW  = UW - 7;
	localparam int unsigned A1W = AW - 17;
	localparam int unsigned DW  = AW - 9;
	localparam int unsigned ZW  = ((DW > 20) ? DW : 20) + 1;
	localparam int unsigned K1  = A1W + 10;
	localparam int unsigned X2W = 27;
	localparam int unsigned K2  = X2W + 10;
	localparam int unsigned RW  = A1W + 10;

	localparam logic [K1-1:0] M1 = K1'(((64'd1 << K1) + 64'd674) / 64'd675);
	localparam logic [K2-1:0] M2 = K2'(((64'd1 << K2) + 64'd674) / 64'd675);

	logic [A1W-1:0]     a1_s2, q1_s2, q1_s3, q1_s4;
	logic [16:0]        a0_s2, q2_s4;
	logic [6:0]         n7_s2, n7_s3, n7_s4;
	logic [X2W-1:0]     x2_s3, x2_s4;
	flags_t             fl_s2, fl_s3, fl_s4;
	logic               valid_s2, valid_s3, valid_s4;
	logic [K1+A1W-1:0]  p1;
	logic [K2+X2W-1:0]  p2;
	logic [RW-1:0]      r1w;
	logic [X2W-1:0]     r2w;
	logic [AW-1:0]      days_full;
	logic [DW-1:0]      days;

	assign p1 = {{K1{1'b0}}, secs_s1[UW-1:24]} * {{A1W{1'b0}}, M1};
	assign r1w = RW'(a1_s2) - RW'(q1_s2) * RW'(675);
	assign p2 = {{K2{1'b0}}, x2_s3} * {{X2W{1'b0}}, M2};
	assign r2w = x2_s4 - X2W'(q2_s4) * X2W'(675);
	assign days_full = {q1_s4, q2_s4};
	assign days = days_full[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s2    <= secs_s1[UW-1:24];
			q1_s2    <= p1[K1 +: A1W];
			a0_s2    <= secs_s1[23:7];
			n7_s2    <= secs_s1[6:0];
			fl_s2    <= flags_s1;

			q1_s3    <= q1_s2;
			x2_s3    <= {r1w[9:0], a0_s2};
			n7_s3    <= n7_s2;
			fl_s3    <= fl_s2;

			q1_s4    <= q1_s3;
			q2_s4    <= p2[K2 +: 17];
			x2_s4    <= x2_s3;
			n7_s4    <= n7_s3;
			fl_s4    <= fl_s3;

			z_s5     <= ZW'(days) + ZW'(719468);
			dp4_s5   <= (DW+1)'(days) + (DW+1)'(4);
			tod_s5   <= {r2w[9:0], n7_s4};
			flags_s5 <= fl_s4;
		end
	end

endmodule

// File: hw/rtl/ecal_date.sv
// ----------------------------------------------------------------------------
// ecal_date: civil date, weekday and time of day
// Closed-form day to date conversion over March-based years, with the
// time of day and weekday split alongside, nine stages deep.
// ----------------------------------------------------------------------------
module ecal_date #(
	parameter int unsigned EPOCH_SECONDS_BITS = 36
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   valid_s5,
	input  logic [((EPOCH_SECONDS_BITS-15 > 20) ?
		EPOCH_SECONDS_BITS-15 : 20):0]              z_s5,
	input  logic [EPOCH_SECONDS_BITS-15:0]          dp4_s5,
	input  logic [16:0]                            tod_s5,
	input  ecal_pkg::flags_t                       flags_s5,
	output logic                                   valid_s14,
	output ecal_pkg::cal_t                         cal_s14
);
	import ecal_pkg::*;

	localparam int unsigned DW  = EPOCH_SECONDS_BITS - 15;
	localparam int unsigned DW1 = DW + 1;
	localparam int unsigned ZW  = ((DW > 20) ? DW : 20) + 1;
	localparam int unsigned EW  = ZW - 17;
	localparam int unsigned YW  = EW + 9;
	localparam int unsigned KE  = ZW + 18;
	localparam int unsigned KW  = DW1 + 3;

	localparam logic [KE-1:0] ME   = KE'(((64'd1 << KE) + 64'd146096) / 64'd146097);
	localparam logic [KW-1:0] MW   = KW'(((64'd1 << KW) + 64'd6) / 64'd7);
	localparam logic [28:0]   MH   = 29'(((64'd1 << 29) + 64'd3599) / 64'd3600);
	localparam logic [17:0]   MMN  = 18'(((64'd1 << 18) + 64'd59) / 64'd60);
	localparam logic [28:0]   M14  = 29'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam logic [26:0]   M365 = 27'(((64'd1 << 27) + 64'd364) / 64'd365);
	localparam logic [18:0]   M153 = 19'(((64'd1 << 19) + 64'd152) / 64'd153);

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] wday;
		flags_t     flags;
	} hold_t;

	logic valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;
	logic valid_s11, valid_s12, valid_s13;

	logic [EW-1:0]  era_s6, era_s7, era_s8, era_s9, era_s10;
	logic [ZW-1:0]  z_s6;
	logic [DW1-1:0] wq_s6, dp4_s6;
	logic [4:0]     hh_s6;
	logic [16:0]    tod_s6;
	flags_t         fl_s6;
	logic [17:0]    doe_s7, doe_s8, doe_s9, doe_s10, num_s9;
	logic [11:0]    sr_s7, sr_s8;
	logic [6:0]     c1_s8;
	logic [2:0]     c2_s8;
	logic           c3_s8;
	logic [5:0]     mm_s8;
	logic [8:0]     yoe_s10, yoe_s11, yoe_s12, doy_s11, doy_s12;
	logic [YW-1:0]  y_s11, y_s12;
	logic [3:0]     mp_s12, m0_s13;
	logic [4:0]     dom_s13;
	logic [11:0]    year_s13;
	logic           leap_s13;
	hold_t          hold_s7, hold_s8, hold_s9, hold_s10, hold_s11, hold_s12, hold_s13;

	logic [KE+ZW-1:0]  pe;
	logic [KW+DW1-1:0] pw;
	logic [45:0]       ph;
	logic [46:0]       p14;
	logic [29:0]       pmn;
	logic [44:0]       p365;
	logic [29:0]       p153;
	logic [10:0]       t5;
	logic [2:0]        y100;
	logic [17:0]       base;
	logic              inc;
	logic [8:0]        yy;
	logic [8:0]        dom_w;

	assign pe  = {{KE{1'b0}}, z_s5} * {{ZW{1'b0}}, ME};
	assign pw  = {{KW{1'b0}}, dp4_s5} * {{DW1{1'b0}}, MW};
	assign ph  = {29'b0, tod_s5} * {17'b0, MH};
	assign p14 = {29'b0, doe_s7} * {18'b0, M14};
	assign pmn = {18'b0, sr_s7} * {12'b0, MMN};
	assign p365 = {27'b0, num_s9} * {18'b0, M365};
	assign t5   = 11'(doy_s11) * 11'(5) + 11'(2);
	assign p153 = {19'b0, t5} * {11'b0, M153};

	assign y100 = 3'(yoe_s10 >= 9'd100) + 3'(yoe_s10 >= 9'd200) + 3'(yoe_s10 >= 9'd300);
	assign base = 18'(yoe_s10) * 18'(365) + 18'(yoe_s10 >> 2) - 18'(y100);

	assign inc   = (mp_s12 >= 4'd10);
	assign yy    = yoe_s12 + 9'(inc);
	assign dom_w = doy_s12 - march_start(mp_s12) + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
			valid_s14 <= 1'b0;
		end else if (en) begin
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
			valid_s13 <= valid_s12;
			valid_s14 <= valid_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			era_s6  <= pe[KE +: EW];
			z_s6    <= z_s5;
			wq_s6   <= pw[KW +: DW1];
			dp4_s6  <= dp4_s5;
			hh_s6   <= ph[29 +: 5];
			tod_s6  <= tod_s5;
			fl_s6   <= flags_s5;

			doe_s7  <= 18'(z_s6 - ZW'(era_s6) * ZW'(146097));
			era_s7  <= era_s6;
			sr_s7   <= 12'(tod_s6 - 17'(hh_s6) * 17'(3600));
			hold_s7.hour   <= hh_s6;
			hold_s7.minute <= '0;
			hold_s7.second <= '0;
			hold_s7.wday   <= 3'(dp4_s6 - DW1'(wq_s6) * DW1'(7));
			hold_s7.flags  <= fl_s6;

			c1_s8   <= p14[29 +: 7];
			c2_s8   <= 3'(doe_s7 >= 18'd36524) + 3'(doe_s7 >= 18'd73048)
				+ 3'(doe_s7 >= 18'd109572) + 3'(doe_s7 >= 18'd146096);
			c3_s8   <= (doe_s7 == 18'd146096);
			doe_s8  <= doe_s7;
			era_s8  <= era_s7;
			mm_s8   <= pmn[18 +: 6];
			sr_s8   <= sr_s7;
			hold_s8 <= hold_s7;

			num_s9  <= doe_s8 - 18'(c1_s8) + 18'(c2_s8) - 18'(c3_s8);
			doe_s9  <= doe_s8;
			era_s9  <= era_s8;
			hold_s9 <= '{hour: hold_s8.hour, minute: mm_s8,
				second: 6'(sr_s8 - 12'(mm_s8) * 12'(60)),
				wday: hold_s8.wday, flags: hold_s8.flags};

			yoe_s10  <= p365[27 +: 9];
			doe_s10  <= doe_s9;
			era_s10  <= era_s9;
			hold_s10 <= hold_s9;

			doy_s11  <= 9'(doe_s10 - base);
			y_s11    <= YW'(era_s10) * YW'(400) + YW'(yoe_s10);
			yoe_s11  <= yoe_s10;
			hold_s11 <= hold_s10;

			mp_s12   <= p153[19 +: 4];
			doy_s12  <= doy_s11;
			y_s12    <= y_s11;
			yoe_s12  <= yoe_s11;
			hold_s12 <= hold_s11;

			m0_s13   <= inc ? (mp_s12 - 4'd10) : (mp_s12 + 4'd2);
			dom_s13  <= dom_w[4:0];
			year_s13 <= 12'((YW+1)'(y_s12) + (YW+1)'(inc) - (YW+1)'(1900));
			leap_s13 <= (yy[1:0] == 2'd0) && (yy != 9'd100) && (yy != 9'd200)
				&& (yy != 9'd300);
			hold_s13 <= hold_s12;

			cal_s14.hour_of_day      <= hold_s13.hour;
			cal_s14.minute_of_hour   <= hold_s13.minute;
			cal_s14.second_of_minute <= hold_s13.second;
			cal_s14.week_day         <= hold_s13.wday;
			cal_s14.years_since_1900 <= year_s13;
			cal_s14.day_of_year      <= month_start(m0_s13) + 9'(dom_s13) - 9'd1
				+ 9'(leap_s13 && (m0_s13 >= 4'd2));
			cal_s14.month_index      <= m0_s13;
			cal_s14.day_of_month     <= dom_s13;
			cal_s14.daylight_flag    <= hold_s13.flags.daylight;
			cal_s14.clamped          <= hold_s13.flags.clamped;
		end
	end

endmodule

// File: hw/rtl/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: Unix seconds to broken-down Gregorian time
// Pipelined converter from epoch seconds to time of day, weekday and date.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the stamp channel is a count of seconds since 1970-01-01 UTC.
// The zone offset (seconds west, register 0) is subtracted and, with the
// daylight register (register 1) set, one hour is added. A negative result
// is clamped to zero and flagged. Each item gives one item on the cal
// channel. Configuration is written on the cfg channel, which is always
// ready; the user must write it only while no item is in flight, which
// the block itself does not enforce. One item is accepted in every cycle
// while the receiver does not stall. The 14 register stages are the zone
// adjustment, the division by 86400 and the closed-form date arithmetic,
// with only the month stage chaining two multiplies.
// Reset clears the pipeline valid bits and sets both registers to zero.
// When the receiver stalls, the whole pipeline holds and stamp.ready falls;
// nothing is lost or repeated.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar #(
	parameter int unsigned EPOCH_SECONDS_BITS = 36
) (
	input  logic         clk,
	input  logic         arst_n,
	ecal_cfg_if.sink     cfg,
	ecal_stamp_if.sink   stamp,
	ecal_cal_if.source   cal
);
	import ecal_pkg::*;

	localparam int unsigned DW = EPOCH_SECONDS_BITS - 15;
	localparam int unsigned ZW = ((DW > 20) ? DW : 20) + 1;

	logic                        en;
	logic                        valid_s1, valid_s5, valid_s14;
	logic [EPOCH_SECONDS_BITS:0] secs_s1;
	flags_t                      flags_s1, flags_s5;
	logic [ZW-1:0]               z_s5;
	logic [DW:0]                 dp4_s5;
	logic [16:0]                 tod_s5;
	cal_t                        cal_s14;

	assign en = !valid_s14 || cal.ready;
	assign stamp.ready = en;

	ecal_adjust #(.EPOCH_SECONDS_BITS(EPOCH_SECONDS_BITS)) u_adjust (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg),
		.in_valid(stamp.valid), .epoch_seconds(stamp.epoch_seconds),
		.valid_s1(valid_s1), .secs_s1(secs_s1), .flags_s1(flags_s1)
	);

	ecal_daydiv #(.EPOCH_SECONDS_BITS(EPOCH_SECONDS_BITS)) u_daydiv (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_s1(valid_s1), .secs_s1(secs_s1), .flags_s1(flags_s1),
		.valid_s5(valid_s5), .z_s5(z_s5), .dp4_s5(dp4_s5), .tod_s5(tod_s5),
		.flags_s5(flags_s5)
	);

	ecal_date #(.EPOCH_SECONDS_BITS(EPOCH_SECONDS_BITS)) u_date (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_s5(valid_s5), .z_s5(z_s5), .dp4_s5(dp4_s5), .tod_s5(tod_s5),
		.flags_s5(flags_s5), .valid_s14(valid_s14), .cal_s14(cal_s14)
	);

	assign cal.valid            = valid_s14;
	assign cal.hour_of_day      = cal_s14.hour_of_day;
	assign cal.minute_of_hour   = cal_s14.minute_of_hour;
	assign cal.second_of_minute = cal_s14.second_of_minute;
	assign cal.week_day         = cal_s14.week_day;
	assign cal.years_since_1900 = cal_s14.years_since_1900;
	assign cal.day_of_year      = cal_s14.day_of_year;
	assign cal.month_index      = cal_s14.month_index;
	assign cal.day_of_month     = cal_s14.day_of_month;
	assign cal.daylight_flag    = cal_s14.daylight_flag;
	assign cal.clamped          = cal_s14.clamped;

`ifndef SYNTH
	a_clamp_is_epoch: assert property (@(posedge clk) disable iff (!arst_n)
		cal.valid && cal.clamped |-> cal.years_since_1900 == 12'd70
		&& cal.day_of_year == 9'd0 && cal.hour_of_day == 5'd0
		&& cal.minute_of_hour == 6'd0 && cal.week_day == 3'd4)
		else $error("clamped item is not the epoch");

	a_field_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal.valid |-> cal.hour_of_day < 5'd24 && cal.minute_of_hour < 6'd60
		&& cal.second_of_minute < 6'd60 && cal.week_day < 3'd7
		&& cal.month_index < 4'd12 && cal.day_of_month != 5'd0)
		else $error("calendar field out of range");

	a_january_yday: assert property (@(posedge clk) disable iff (!arst_n)
		cal.valid && cal.month_index == 4'd0
		|-> cal.day_of_year == 9'(cal.day_of_month) - 9'd1)
		else $error("day of year disagrees with January date");
`endif

endmodule

// File: sim/tb_epoch_seconds_to_calendar_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_if: calendar expectation store for the testbench
// Holds the predicted calendar items of accepted time stamps in order and
// compares each received item with the oldest of them, field by field.
// ----------------------------------------------------------------------------
class calendar_scoreboard;
	ecal_pkg::cal_t pending[$];
	int             errors;
	logic signed [16:0] zone_west;
	logic               daylight;

	function new();
		errors = 0;
		zone_west = '0;
		daylight = 1'b0;
	endfunction

	function automatic bit is_leap(input longint unsigned yr);
		if (yr % 4 != 0) return 1'b0;
		if (yr % 100 != 0) return 1'b1;
		return (yr % 400 == 0);
	endfunction

	function automatic ecal_pkg::cal_t to_calendar(input logic [35:0] stamp);
		longint         t;
		longint unsigned ut, days, secs, z, era, doe, yoe, y, doy, mp, d, m, yr;
		int unsigned    m0, yday;
		int unsigned    mstart[12];
		ecal_pkg::cal_t c;
		mstart = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
		t = longint'(stamp) - longint'(zone_west) + (daylight ? 3600 : 0);
		c.clamped = (t < 0);
		if (t < 0) t = 0;
		ut = unsigned'(t);
		days = ut / 86400;
		secs = ut % 86400;
		z = days + 719468;
		era = z / 146097;
		doe = z - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		y = yoe + era * 400;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		d = doy - (153 * mp + 2) / 5 + 1;
		m = (mp < 10) ? mp + 3 : mp - 9;
		yr = y + ((m <= 2) ? 1 : 0);
		m0 = 32'(m - 1);
		yday = 32'(longint'(mstart[m0]) + longint'(d - 1)
			+ ((m0 >= 2) ? longint'(is_leap(yr)) : 0));
		c.hour_of_day = 5'(secs / 3600);
		c.minute_of_hour = 6'((secs % 3600) / 60);
		c.second_of_minute = 6'(secs % 60);
		c.week_day = 3'((days + 4) % 7);
		c.years_since_1900 = 12'(yr - 1900);
		c.day_of_year = 9'(yday);
		c.month_index = 4'(m0);
		c.day_of_month = 5'(d);
		c.daylight_flag = daylight;
		return c;
	endfunction

	function void note_stamp(input logic [35:0] stamp);
		pending.push_back(to_calendar(stamp));
	endfunction

	function void check_calendar(input ecal_pkg::cal_t got);
		ecal_pkg::cal_t e;
		if (pending.size() == 0) begin
			$error("calendar item with no expectation");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.hour_of_day !== e.hour_of_day) begin
			$error("hour_of_day exp %0d got %0d", e.hour_of_day, got.hour_of_day); errors++;
		end
		if (got.minute_of_hour !== e.minute_of_hour) begin
			$error("minute_of_hour exp %0d got %0d", e.minute_of_hour, got.minute_of_hour);
			errors++;
		end
		if (got.second_of_minute !== e.second_of_minute) begin
			$error("second_of_minute exp %0d got %0d", e.second_of_minute,
				got.second_of_minute);
			errors++;
		end
		if (got.week_day !== e.week_day) begin
			$error("week_day exp %0d got %0d", e.week_day, got.week_day); errors++;
		end
		if (got.years_since_1900 !== e.years_since_1900) begin
			$error("years_since_1900 exp %0d got %0d", e.years_since_1900,
				got.years_since_1900);
			errors++;
		end
		if (got.day_of_year !== e.day_of_year) begin
			$error("day_of_year exp %0d got %0d", e.day_of_year, got.day_of_year); errors++;
		end
		if (got.month_index !== e.month_index) begin
			$error("month_index exp %0d got %0d", e.month_index, got.month_index); errors++;
		end
		if (got.day_of_month !== e.day_of_month) begin
			$error("day_of_month exp %0d got %0d", e.day_of_month, got.day_of_month);
			errors++;
		end
		if (got.daylight_flag !== e.daylight_flag) begin
			$error("daylight_flag exp %0d got %0d", e.daylight_flag, got.daylight_flag);
			errors++;
		end
		if (got.clamped !== e.clamped) begin
			$error("clamped exp %0d got %0d", e.clamped, got.clamped); errors++;
		end
	endfunction
endclass

// File: sim/tb_epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar: testbench of the epoch to calendar converter
// Drives time stamps under several zone and daylight settings, with random
// gaps on both channels, and checks every calendar item against a predictor.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;
	import ecal_pkg::*;

	localparam int WATCHDOG_CYCLES = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	ecal_cfg_if   cfg();
	ecal_stamp_if #(.EPOCH_SECONDS_BITS(36)) stamp();
	ecal_cal_if   cal();

	calendar_scoreboard board = new();
	bit   sink_busy_free = 1'b0;
	bit   source_busy_free = 1'b0;
	int   idle_cycles = 0;
	int   sent = 0;

	epoch_seconds_to_calendar #(.EPOCH_SECONDS_BITS(36)) DUT (
		.clk(clk), .arst_n(arst_n), .cfg(cfg.sink), .stamp(stamp.sink), .cal(cal.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
		stamp.valid = 1'b0; stamp.epoch_seconds = '0;
		cal.ready = 1'b0;
	end

	// Receiver: random back-pressure, none during the quiet stretch.
	always @(negedge clk) begin
		cal.ready <= sink_busy_free ? 1'b1 : ($urandom_range(99) >= 32);
	end

	always @(posedge clk) begin
		if (arst_n && cal.valid && cal.ready) begin
			cal_t got;
			got.hour_of_day = cal.hour_of_day;
			got.minute_of_hour = cal.minute_of_hour;
			got.second_of_minute = cal.second_of_minute;
			got.week_day = cal.week_day;
			got.years_since_1900 = cal.years_since_1900;
			got.day_of_year = cal.day_of_year;
			got.month_index = cal.month_index;
			got.day_of_month = cal.day_of_month;
			got.daylight_flag = cal.daylight_flag;
			got.clamped = cal.clamped;
			board.check_calendar(got);
		end
		if (arst_n && !((cal.valid && cal.ready) || (stamp.valid && stamp.ready)
				|| (cfg.valid && cfg.ready))) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("tb: failure");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

	task automatic write_register(input logic [1:0] idx, input logic [16:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_ZONE_OFFSET) board.zone_west = value;
		else if (idx == REG_DAYLIGHT) board.daylight = value[0];
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic send_stamp(input logic [35:0] value);
		@(negedge clk);
		if (!source_busy_free) begin
			while ($urandom_range(99) < 32) @(negedge clk);
		end
		stamp.valid <= 1'b1;
		stamp.epoch_seconds <= value;
		do @(posedge clk); while (!stamp.ready);
		board.note_stamp(value);
		sent++;
		@(negedge clk);
		stamp.valid <= 1'b0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [35:0] random_stamp();
		case ($urandom_range(5))
			0: return 36'({$urandom(), $urandom()});
			1: return 36'($urandom_range(200000));
			2: return 36'hF_FFFF_FFFF - 36'($urandom_range(200000));
			// Around the end of February in 2000 and 2100, across the turn of a day.
			3: return 36'd951782400 + 36'($urandom_range(172800)) - 36'd86400;
			4: return 36'd4107542400 + 36'($urandom_range(172800)) - 36'd86400;
			default: return {4'd0, $urandom()};
		endcase
	endfunction

	initial begin
		logic [35:0] directed[$];
		int          zones[6];
		zones = '{0, -50400, 50400, 3600, -65536, 65535};
		directed = '{36'd0, 36'd1, 36'd59, 36'd3599, 36'd86399, 36'd86400,
			36'd951782400, 36'd951868800, 36'd4107542400, 36'd4107628800,
			36'd946684799, 36'd946684800, 36'd68256000, 36'd2147483647,
			36'hF_FFFF_FFFF, 36'hA_AAAA_AAAA, 36'h5_5555_5555, 36'd31535999};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed[i]) send_stamp(directed[i]);
		drain();
		for (int z = 0; z < 6; z++) begin
			write_register(REG_ZONE_OFFSET, 17'(zones[z]));
			write_register(REG_DAYLIGHT, 17'(z[0]));
			for (int k = 0; k < 20; k++) send_stamp(36'($urandom_range(100000)));
			source_busy_free = (z == 3);
			sink_busy_free = (z == 3);
			for (int k = 0; k < 250; k++) send_stamp(random_stamp());
			source_busy_free = 1'b0;
			sink_busy_free = 1'b0;
			drain();
		end
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

// File: filelist.f
hw/rtl/ecal_pkg.sv
hw/rtl/ecal_if.sv
hw/rtl/ecal_adjust.sv
hw/rtl/ecal_daydiv.sv
hw/rtl/ecal_date.sv
hw/rtl/epoch_seconds_to_calendar.sv
sim/tb_epoch_seconds_to_calendar_if.sv
sim/tb_epoch_seconds_to_calendar.sv
